[hw/rtl/bsva_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// bsva_pkg
// Shared types, operation codes and divider step for the byte stack VM ALU.
// ============================================================================
package bsva_pkg;

    typedef logic [4:0] t_kind;
    typedef logic [1:0] t_status;
    typedef logic [7:0] t_byte;

    localparam t_kind K_ADD   = 5'd0;
    localparam t_kind K_SUB   = 5'd1;
    localparam t_kind K_MUL   = 5'd2;
    localparam t_kind K_DIV   = 5'd3;
    localparam t_kind K_MOD   = 5'd4;
    localparam t_kind K_EQ    = 5'd5;
    localparam t_kind K_GT    = 5'd6;
    localparam t_kind K_LT    = 5'd7;
    localparam t_kind K_LE    = 5'd8;
    localparam t_kind K_GE    = 5'd9;
    localparam t_kind K_NE    = 5'd10;
    localparam t_kind K_AND   = 5'd11;
    localparam t_kind K_OR    = 5'd12;
    localparam t_kind K_XOR   = 5'd13;
    localparam t_kind K_MIN   = 5'd14;
    localparam t_kind K_MAX   = 5'd15;
    localparam t_kind K_NOT   = 5'd16;
    localparam t_kind K_ABS   = 5'd17;
    localparam t_kind K_NEG   = 5'd18;
    localparam t_kind K_SHIFT = 5'd19;

    localparam t_status ST_OK          = 2'd0;
    localparam t_status ST_DIVZERO     = 2'd1;
    localparam t_status ST_UNSUPPORTED = 2'd2;

    // divider: 8 quotient bits, 2 per pipeline stage
    localparam int DIV_STAGES = 4;
    localparam int DIV_BPS    = 2;

    typedef struct packed {
        logic  q;
        t_byte rem;
    } t_div_step;

    // one restoring division step
    function automatic t_div_step div_step(input t_byte rem, input logic nbit,
                                           input t_byte den);
        logic [8:0] sh;
        t_div_step  st;
        sh = {rem, nbit};
        if (sh >= {1'b0, den}) begin
            st.q   = 1'b1;
            st.rem = 8'(sh - {1'b0, den});
        end else begin
            st.q   = 1'b0;
            st.rem = sh[7:0];
        end
        return st;
    endfunction

endpackage

[hw/rtl/bsva_div.sv]
`timescale 1ns / 1ps
// ============================================================================
// bsva_div
// Pipelined 8-bit unsigned restoring divider, two quotient bits per stage;
// quotient and remainder are taken from the registers of the last stage.
// ============================================================================
module bsva_div (
    input  logic                i_clk,
    input  bsva_pkg::t_byte     i_num,
    input  bsva_pkg::t_byte     i_den,
    output bsva_pkg::t_byte     o_quo,
    output bsva_pkg::t_byte     o_rem
);

    localparam int NS = bsva_pkg::DIV_STAGES;
    localparam int BP = bsva_pkg::DIV_BPS;

    bsva_pkg::t_byte r_rem [NS];
    bsva_pkg::t_byte r_quo [NS];
    bsva_pkg::t_byte r_num [NS];
    bsva_pkg::t_byte r_den [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stg
        bsva_pkg::t_byte   w_rem_in;
        bsva_pkg::t_byte   w_quo_in;
        bsva_pkg::t_byte   w_num_in;
        bsva_pkg::t_byte   w_den_in;
        bsva_pkg::t_byte   n_rem;
        bsva_pkg::t_byte   n_quo;
        bsva_pkg::t_div_step w_st [BP];

        if (k == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_quo_in = '0;
            assign w_num_in = i_num;
            assign w_den_in = i_den;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_quo_in = r_quo[k-1];
            assign w_num_in = r_num[k-1];
            assign w_den_in = r_den[k-1];
        end

        for (genvar j = 0; j < BP; j++) begin : g_bit
            localparam int Idx = 7 - BP * k - j;
            if (j == 0) begin : g_j0
                assign w_st[j] = bsva_pkg::div_step(w_rem_in, w_num_in[Idx], w_den_in);
            end else begin : g_jn
                assign w_st[j] = bsva_pkg::div_step(w_st[j-1].rem, w_num_in[Idx],
                                                    w_den_in);
            end
        end

        always_comb begin
            n_quo = w_quo_in;
            for (int j = 0; j < BP; j++) begin
                n_quo[7 - BP * k - j] = w_st[j].q;
            end
            n_rem = w_st[BP-1].rem;
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem;
            r_quo[k] <= n_quo;
            r_num[k] <= w_num_in;
            r_den[k] <= w_den_in;
        end
    end

    assign o_quo = r_quo[NS-1];
    assign o_rem = r_rem[NS-1];

endmodule

[hw/rtl/byte_stack_vm_alu_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// byte_stack_vm_alu_top
// Unsigned 8-bit execute unit of a stack VM: arithmetic, compare, logic,
// min/max, unary and signed-distance shift ops, one result word per word in.
// ============================================================================
// Usage:
//   Input: drive i_kind, i_lhs, i_rhs and raise start. A word is taken at
//   every rising edge with start high and busy low; busy is always low, so
//   one word can enter every cycle.
//   Output: o_result and o_status appear for one cycle with o_strobe high,
//   in the order words were taken. The receiver cannot hold them off.
//   Path: the result passes through the input register, four divider
//   stages of two quotient bits each, and the output register.
//   Throughput is one word per cycle; the pipelined divider sets
//   the depth, all other ops are delayed to match it.
//   Status: 0 ok, 1 div/mod by zero (result 0), 2 unknown kind (result 0).
//   Reset: synchronous, active low, clears all valid bits; words in flight
//   are dropped.
// ============================================================================
module byte_stack_vm_alu_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [4:0]          i_kind,
    input  logic [7:0]          i_lhs,
    input  logic [7:0]          i_rhs,
    output logic                o_strobe,
    output logic [7:0]          o_result,
    output logic [1:0]          o_status
);

    localparam int NS = bsva_pkg::DIV_STAGES;

    typedef struct packed {
        logic                  sel_div;
        logic                  sel_mod;
        bsva_pkg::t_byte       res;
        bsva_pkg::t_status     st;
    } t_side;

    // stage 1: input register
    logic                r_s1_vld;
    bsva_pkg::t_kind     r_s1_kind;
    bsva_pkg::t_byte     r_s1_lhs;
    bsva_pkg::t_byte     r_s1_rhs;

    // side path delay, aligned with divider
    logic                r_vld [NS];
    t_side               r_side [NS];

    bsva_pkg::t_byte     w_quo;
    bsva_pkg::t_byte     w_rem;
    t_side               n_side;
    bsva_pkg::t_byte     w_ndist;
    bsva_pkg::t_byte     w_shl;
    bsva_pkg::t_byte     w_shr;
    logic [15:0]         w_prod;

    logic                r_strobe;
    bsva_pkg::t_byte     r_result;
    bsva_pkg::t_status   r_status;
    bsva_pkg::t_byte     n_result;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
        end
        r_s1_kind <= i_kind;
        r_s1_lhs  <= i_lhs;
        r_s1_rhs  <= i_rhs;
    end

    bsva_div u_div (
        .i_clk (i_clk),
        .i_num (r_s1_lhs),
        .i_den (r_s1_rhs),
        .o_quo (w_quo),
        .o_rem (w_rem)
    );

    assign w_prod  = 16'(r_s1_lhs) * 16'(r_s1_rhs);
    assign w_ndist = 8'(~r_s1_rhs + 8'd1);
    assign w_shl   = (r_s1_rhs[6:3] != 4'd0) ? 8'd0 : 8'(r_s1_lhs << r_s1_rhs[2:0]);
    assign w_shr   = (w_ndist[7:3] != 5'd0) ? 8'd0 : 8'(r_s1_lhs >> w_ndist[2:0]);

    always_comb begin
        n_side.sel_div = 1'b0;
        n_side.sel_mod = 1'b0;
        n_side.res     = '0;
        n_side.st      = bsva_pkg::ST_OK;
        unique case (r_s1_kind)
            bsva_pkg::K_ADD:   n_side.res = 8'(r_s1_lhs + r_s1_rhs);
            bsva_pkg::K_SUB:   n_side.res = 8'(r_s1_lhs - r_s1_rhs);
            bsva_pkg::K_MUL:   n_side.res = w_prod[7:0];
            bsva_pkg::K_DIV: begin
                if (r_s1_rhs == 8'd0) begin
                    n_side.st = bsva_pkg::ST_DIVZERO;
                end else begin
                    n_side.sel_div = 1'b1;
                end
            end
            bsva_pkg::K_MOD: begin
                if (r_s1_rhs == 8'd0) begin
                    n_side.st = bsva_pkg::ST_DIVZERO;
                end else begin
                    n_side.sel_mod = 1'b1;
                end
            end
            bsva_pkg::K_EQ:    n_side.res = {7'd0, r_s1_lhs == r_s1_rhs};
            bsva_pkg::K_GT:    n_side.res = {7'd0, r_s1_lhs >  r_s1_rhs};
            bsva_pkg::K_LT:    n_side.res = {7'd0, r_s1_lhs <  r_s1_rhs};
            bsva_pkg::K_LE:    n_side.res = {7'd0, r_s1_lhs <= r_s1_rhs};
            bsva_pkg::K_GE:    n_side.res = {7'd0, r_s1_lhs >= r_s1_rhs};
            bsva_pkg::K_NE:    n_side.res = {7'd0, r_s1_lhs != r_s1_rhs};
            bsva_pkg::K_AND:   n_side.res = r_s1_lhs & r_s1_rhs;
            bsva_pkg::K_OR:    n_side.res = r_s1_lhs | r_s1_rhs;
            bsva_pkg::K_XOR:   n_side.res = r_s1_lhs ^ r_s1_rhs;
            bsva_pkg::K_MIN:   n_side.res = (r_s1_lhs <= r_s1_rhs) ? r_s1_lhs : r_s1_rhs;
            bsva_pkg::K_MAX:   n_side.res = (r_s1_lhs >= r_s1_rhs) ? r_s1_lhs : r_s1_rhs;
            bsva_pkg::K_NOT:   n_side.res = ~r_s1_rhs;
            bsva_pkg::K_ABS:   n_side.res = r_s1_rhs;
            bsva_pkg::K_NEG:   n_side.res = 8'(8'd0 - r_s1_rhs);
            bsva_pkg::K_SHIFT: n_side.res = r_s1_rhs[7] ? w_shr : w_shl;
            default:           n_side.st  = bsva_pkg::ST_UNSUPPORTED;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= r_s1_vld;
            for (int k = 1; k < NS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
        r_side[0] <= n_side;
        for (int k = 1; k < NS; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    always_comb begin
        priority if (r_side[NS-1].sel_div) begin
            n_result = w_quo;
        end else if (r_side[NS-1].sel_mod) begin
            n_result = w_rem;
        end else begin
            n_result = r_side[NS-1].res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vld[NS-1];
        end
        r_result <= n_result;
        r_status <= r_side[NS-1].st;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;
    assign o_status = r_status;

endmodule
